[design/urxfifo_pkg.sv]
// urxfifo_pkg: shared types and constants for the 2x-oversampled UART receiver with FIFO.
// Used by urxfifo_core and the top level uart_rx_2x_oversample_fifo.
// No dependencies.
`timescale 1ns / 1ps

package urxfifo_pkg;

  // Field widths
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned PHASE_W = 5;

  // Default FIFO depth for the top-level parameter
  localparam int unsigned FIFO_DEPTH_DEF = 32;

  // Receive phases of interest
  localparam logic [PHASE_W-1:0] PHASE_IDLE       = 5'd0;
  localparam logic [PHASE_W-1:0] PHASE_START_LATE = 5'd1;
  localparam logic [PHASE_W-1:0] PHASE_FIRST_BIT  = 5'd2;
  localparam logic [PHASE_W-1:0] PHASE_STORE      = 5'd18;
  localparam logic [PHASE_W-1:0] PHASE_COMMIT     = 5'd19;

  // Item actions
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Register port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_RX_ENABLE = 3'd0;
  localparam logic RX_ENABLE_RST = 1'b1;

  // Input word
  typedef struct packed {
    logic action;
    logic rx_level;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [FILL_W-1:0] fill_count;
    logic              byte_received;
  } out_word_t;

endpackage

[design/urxfifo_ram.sv]
// urxfifo_ram: generic single-write, single-read RAM with registered read data.
// Read-first: a read and write to the same address in one cycle return the old data.
// No dependencies.
`timescale 1ns / 1ps

module urxfifo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/urxfifo_core.sv]
// urxfifo_core: receive phase machine, shift byte, FIFO pointers, valid bits and store.
// Registers one result word per accepted item; the head byte comes from urxfifo_ram.
// Depends on urxfifo_pkg and urxfifo_ram.
`timescale 1ns / 1ps

module urxfifo_core
  import urxfifo_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      rx_enable_i,
  input  in_word_t  in_word_i,
  output out_word_t res_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned EXT_W = (PTR_W > FILL_W) ? PTR_W : FILL_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [DATA_W-1:0]     shift_q, shift_d;
  logic [PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [FIFO_DEPTH-1:0] vld_q, vld_d;

  logic                  active;
  logic                  is_tick;
  logic                  store_we;
  logic                  done;
  logic [PTR_W:0]        diff;
  logic [EXT_W-1:0]      fill_ext;
  logic [DATA_W-1:0]     head_raw;

  // Result-stage registers
  logic                  item_en_q;
  logic                  head_vld_q;
  logic [FILL_W-1:0]     fill_q;
  logic                  done_q;

  assign active   = step_i & rx_enable_i;
  assign is_tick  = (in_word_i.action == ACT_TICK);
  assign store_we = active & is_tick & (phase_q == PHASE_STORE);

  // Receive machine and pointer updates
  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    vld_d    = vld_q;
    done     = 1'b0;
    if (active) begin
      if (!is_tick) begin
        rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end else if (phase_q == PHASE_IDLE) begin
        if (!in_word_i.rx_level) begin
          shift_d = '0;
          phase_d = PHASE_START_LATE;
        end
      end else if (phase_q == PHASE_START_LATE) begin
        phase_d = PHASE_FIRST_BIT;
      end else if (phase_q == PHASE_STORE) begin
        vld_d[wr_ptr_q] = 1'b1;
        phase_d         = PHASE_COMMIT;
      end else if (phase_q >= PHASE_COMMIT) begin
        wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
        phase_d  = PHASE_IDLE;
        done     = 1'b1;
      end else begin
        // data bits sampled on even phases, LSB first
        if (!phase_q[0]) begin
          shift_d = {in_word_i.rx_level, shift_q[DATA_W-1:1]};
        end
        phase_d = phase_q + PHASE_W'(1);
      end
    end
  end

  // Fill level after this item, modulo depth
  always_comb begin
    diff = {1'b0, wr_ptr_d} - {1'b0, rd_ptr_d};
    if (wr_ptr_d < rd_ptr_d) begin
      diff = diff + (PTR_W + 1)'(FIFO_DEPTH);
    end
    fill_ext = EXT_W'(diff[PTR_W-1:0]);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PHASE_IDLE;
      shift_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      vld_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      vld_q    <= vld_d;
    end
  end

  // Result stage, loaded with each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_en_q <= 1'b0;
    end else if (step_i) begin
      item_en_q <= rx_enable_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      head_vld_q <= vld_q[rd_ptr_q];
      fill_q     <= fill_ext[FILL_W-1:0];
      done_q     <= done;
    end
  end

  // FIFO store; read-first so the head reflects the state before the item
  urxfifo_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (shift_q),
    .re_i    (step_i),
    .raddr_i (rd_ptr_q),
    .rdata_o (head_raw)
  );

  // Never-written entries read as zero; disabled items give all zeros
  assign res_o.data_byte     = (item_en_q && head_vld_q) ? head_raw : '0;
  assign res_o.fill_count    = item_en_q ? fill_q : '0;
  assign res_o.byte_received = item_en_q & done_q;

  // Phase counter never runs past the commit phase
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PHASE_COMMIT)
    else $error("receive phase out of range");

  // A commit tick reports a received byte
  a_commit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active && is_tick && phase_q == PHASE_COMMIT |=> res_o.byte_received)
    else $error("commit tick without byte_received");

  // A disabled item changes no pointer and no receive phase
  a_disabled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !rx_enable_i |=> $stable(wr_ptr_q) && $stable(rd_ptr_q) && $stable(phase_q))
    else $error("disabled item changed receiver state");

endmodule

[design/uart_rx_2x_oversample_fifo.sv]
// UART 8N1 receiver sampled at twice the baud rate, with a ring FIFO.
//
// Input channel (in_valid_i / in_ready_o / in_word_i): each word is either a
// sampling tick (action 0) carrying the receive line level, or a read (action 1)
// that pops the head byte. Output channel (out_valid_o / out_ready_i /
// out_word_o): exactly one result word per input word, in order: head byte
// before the item, fill count after it, and a flag for a completed frame.
// Register rx_enable at APB address 0 (reset 1); at 0 results are all zero and
// the receiver state holds. Write it only while the block is idle.
//
// The result stage (registered store read and result fields) loads at the
// accepting edge, then the output register loads from it and drives out_valid_o.
// Throughput: one word per cycle while in_ready_o is high.
// Reset clears the phase machine, pointers and per-entry valid bits; unwritten
// entries read as zero. When the output stalls, the output register and the
// result stage behind it fill, and in_ready_o drops only once both are full.
// Depends on urxfifo_pkg and urxfifo_core.
`timescale 1ns / 1ps

module uart_rx_2x_oversample_fifo
  import urxfifo_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_word_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_word_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic      rx_enable_q;
  logic      accept;
  logic      out_take;
  logic      s1_vld_q, s1_vld_d;
  logic      out_vld_q;
  out_word_t out_word_q;
  out_word_t s1_word;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RX_ENABLE) ? PDATA_W'(rx_enable_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_enable_q <= RX_ENABLE_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RX_ENABLE) begin
      rx_enable_q <= pwdata[0];
    end
  end

  // Handshake: output register frees the result stage, which frees the input
  assign out_take   = !out_vld_q || out_ready_i;
  assign in_ready_o = !s1_vld_q || out_take;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (out_take) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (out_take) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (out_take && s1_vld_q) begin
      out_word_q <= s1_word;
    end
  end

  urxfifo_core #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .rx_enable_i (rx_enable_q),
    .in_word_i   (in_word_i),
    .res_o       (s1_word)
  );

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

  // Every accepted word lands in the result stage
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q)
    else $error("accepted word missing from result stage");

  // A stalled result stage keeps its word intact
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !out_take |=> s1_vld_q && $stable(s1_word))
    else $error("stalled result stage lost its word");

  // Output drains when taken with nothing behind it
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_ready_i && !s1_vld_q |=> !out_valid_o)
    else $error("result word repeated");

endmodule

[tb/sv/uart_rx_2x_oversample_fifo_tb.sv]
// Testbench for uart_rx_2x_oversample_fifo: random serial frames, FIFO reads and
// rx_enable changes, checked word by word against a built-in model of the receiver.
// Depends on urxfifo_pkg and the top level uart_rx_2x_oversample_fifo.
`timescale 1ns / 1ps

module uart_rx_2x_oversample_fifo_tb;
  import urxfifo_pkg::*;

  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned TIMEOUT_NS  = 5_000_000;

  // Receiver model: phase machine, shift register, ring store, pointers
  class rx_fifo_scoreboard;
    bit                 rx_en;
    logic [PHASE_W-1:0] phase;
    logic [DATA_W-1:0]  shreg;
    logic [DATA_W-1:0]  store [FIFO_DEPTH_DEF];
    int unsigned        wr_ptr;
    int unsigned        rd_ptr;
    out_word_t          expq[$];
    int                 errors;
    int                 results;
    int                 frames;
    int                 reads;
    int                 empty_reads;
    int                 overruns;

    function new();
      rx_en  = RX_ENABLE_RST;
      phase  = PHASE_IDLE;
      shreg  = '0;
      wr_ptr = 0;
      rd_ptr = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function int unsigned next_ptr(int unsigned p);
      return (p + 1 >= FIFO_DEPTH_DEF) ? 0 : p + 1;
    endfunction

    function int unsigned fill();
      if (wr_ptr < rd_ptr) return FIFO_DEPTH_DEF - rd_ptr + wr_ptr;
      return wr_ptr - rd_ptr;
    endfunction

    // Advance the model by one accepted word and queue the result it predicts
    function void note_word(in_word_t w);
      out_word_t exp_w;
      exp_w = '0;
      if (rx_en) begin
        exp_w.data_byte = store[rd_ptr];
        if (w.action == ACT_READ) begin
          reads++;
          if (rd_ptr == wr_ptr) empty_reads++;
          rd_ptr = next_ptr(rd_ptr);
        end else if (phase == PHASE_IDLE) begin
          if (!w.rx_level) begin
            shreg = '0;
            phase = PHASE_START_LATE;
          end
        end else if (phase == PHASE_START_LATE) begin
          phase = PHASE_FIRST_BIT;
        end else if (phase == PHASE_STORE) begin
          store[wr_ptr] = shreg;
          phase = PHASE_COMMIT;
        end else if (phase >= PHASE_COMMIT) begin
          if (fill() == FIFO_DEPTH_DEF - 1) overruns++;
          wr_ptr = next_ptr(wr_ptr);
          phase = PHASE_IDLE;
          exp_w.byte_received = 1'b1;
          frames++;
        end else begin
          // data bits sampled on even phases, LSB first
          if (!phase[0]) shreg = {w.rx_level, shreg[DATA_W-1:1]};
          phase = phase + 1'b1;
        end
        exp_w.fill_count = FILL_W'(fill());
      end
      expq.push_back(exp_w);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Compare one output word against the oldest prediction
    task check_word(out_word_t got);
      out_word_t want;
      results++;
      if (expq.size() == 0) begin
        report("result word with nothing pending", 32'(got), '0);
      end else begin
        want = expq.pop_front();
        if (got.data_byte !== want.data_byte)
          report("data_byte", 32'(got.data_byte), 32'(want.data_byte));
        if (got.fill_count !== want.fill_count)
          report("fill_count", 32'(got.fill_count), 32'(want.fill_count));
        if (got.byte_received !== want.byte_received)
          report("byte_received", 32'(got.byte_received), 32'(want.byte_received));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_word_t           in_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_word_t          out_word_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rx_fifo_scoreboard sb = new();
  bit                idle_on;
  bit                hold_req;
  int                stall_left;
  int                words_sent;
  int                holds;
  int                cfg_writes;

  uart_rx_2x_oversample_fifo dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Send one word: optional idle gap, then hold valid until accepted
  task automatic send_word(in_word_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send_tick(bit lvl);
    in_word_t w;
    w.action   = ACT_TICK;
    w.rx_level = lvl;
    send_word(w);
  endtask

  task automatic send_read(bit lvl);
    in_word_t w;
    w.action   = ACT_READ;
    w.rx_level = lvl;
    send_word(w);
  endtask

  // Ticks for frame phases first..last of byte b, two ticks per bit,
  // with reads mixed in at read_pct percent
  task automatic send_frame(logic [7:0] b, int first, int last, int read_pct);
    bit lvl;
    for (int p = first; p <= last; p++) begin
      if ($urandom_range(0, 99) < read_pct) send_read(1'($urandom_range(0, 1)));
      if (p < 2) lvl = 1'b0;
      else if (p < 18) lvl = b[(p - 2) / 2];
      else lvl = 1'b1;
      send_tick(lvl);
    end
  endtask

  // Mostly clean frames, plus cut-off frames, line noise and read bursts
  task automatic run_segment(int n_words, int read_pct);
    int target;
    int kind;
    target = words_sent + n_words;
    while (words_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(8'($urandom_range(0, 255)), 0, 19, read_pct);
      end else if (kind < 80) begin
        send_frame(8'($urandom_range(0, 255)), 0, $urandom_range(1, 18), read_pct);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 4)) send_read(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic send_random(int n);
    in_word_t w;
    repeat (n) begin
      w.action   = 1'($urandom_range(0, 1));
      w.rx_level = 1'($urandom_range(0, 1));
      send_word(w);
    end
  endtask

  // Drop valid and wait for every pending result
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_rx_enable(bit v);
    logic [PDATA_W-1:0] rd;
    wait_idle();
    apb_write(ADDR_RX_ENABLE, PDATA_W'(v));
    sb.rx_en = v;
    cfg_writes++;
    apb_read(ADDR_RX_ENABLE, rd);
    if (rd !== PDATA_W'(v)) sb.report("rx_enable readback", rd, PDATA_W'(v));
  endtask

  // Output side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(out_word_o);
      stall_left = idle_on ? $urandom_range(0, 7) : 0;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("uart_rx_2x_oversample_fifo_tb NOT OK");
    $finish;
  end

  initial begin
    logic [PDATA_W-1:0] rd;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_on    = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apb_read(ADDR_RX_ENABLE, rd);
    if (rd !== PDATA_W'(RX_ENABLE_RST))
      sb.report("rx_enable after reset", rd, PDATA_W'(RX_ENABLE_RST));
    set_rx_enable(1'b1);

    // Directed: idle line, one clean frame, pop it, then reads on an empty FIFO
    send_tick(1'b1);
    send_frame(8'hA5, 0, 19, 0);
    send_read(1'b0);
    send_read(1'b1);
    send_read(1'b0);

    // Extreme bytes, then a light read mix
    send_frame(8'h00, 0, 19, 0);
    send_frame(8'hFF, 0, 19, 10);
    run_segment(220, 5);

    // Disable in the middle of a frame, then finish it after re-enable
    send_frame(8'h6C, 0, 8, 0);
    set_rx_enable(1'b0);
    send_random(20);
    set_rx_enable(1'b1);
    send_frame(8'h6C, 9, 19, 0);

    // Back to back with no mixed-in reads: output held off, FIFO overruns
    idle_on  = 1'b0;
    hold_req = 1'b1;
    holds++;
    run_segment(400, 0);
    wait_idle();

    // Read-heavy traffic drains past empty
    idle_on = 1'b1;
    run_segment(200, 30);
    idle_on = 1'b0;
    run_segment(100, 60);
    hold_req = 1'b1;
    holds++;
    idle_on = 1'b1;
    run_segment(100, 30);

    set_rx_enable(1'b0);
    send_random(15);
    set_rx_enable(1'b1);
    run_segment(60, 20);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("words %0d, results %0d, frames %0d, reads %0d (%0d on empty), overruns %0d",
             words_sent, sb.results, sb.frames, sb.reads, sb.empty_reads, sb.overruns);
    $display("rx_enable writes %0d, long output hold-offs %0d, mismatches %0d",
             cfg_writes, holds, sb.errors);
    if (sb.errors == 0) begin
      $display("uart_rx_2x_oversample_fifo_tb OK");
    end else begin
      $display("uart_rx_2x_oversample_fifo_tb NOT OK");
    end
    $finish;
  end

endmodule
